@@ src/esd_pkg.sv @@
// esd_pkg: types, character constants and lookup functions for the escape decoder.
// No dependencies; imported by every module of the block.
package esd_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;

   localparam int unsigned OUT_DEPTH      = 4;
   localparam int unsigned OUT_PTR_WIDTH  = $clog2(OUT_DEPTH);
   localparam int unsigned OUT_CNT_WIDTH  = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_ZERO  = 2'd2,
      MODE_HEX   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_done;
   } result_type;

   // results handed from the decoder to the output queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] value;
   } ctrl_type;

   function automatic hex_type hex_value(input logic [7:0] c);
      hex_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r.value = c[3:0] + 4'd9;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic ctrl_type control_byte(input logic [7:0] c);
      ctrl_type r;
      r.ok = 1'b1;
      case (c)
         8'h61:          r.value = 8'h07;
         8'h62:          r.value = 8'h08;
         8'h74:          r.value = 8'h09;
         8'h6E:          r.value = 8'h0A;
         8'h76:          r.value = 8'h0B;
         8'h66:          r.value = 8'h0C;
         8'h72:          r.value = 8'h0D;
         CHAR_BACKSLASH: r.value = CHAR_BACKSLASH;
         default: begin
            r.ok    = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

endpackage

@@ src/escape_sequence_decoder.sv @@
// escape_sequence_decoder: top level of the backslash escape decoder.
// Depends on esd_pkg, esd_decode and esd_out_queue.
//
//   channel  | ports                                        | moves
//   ---------+----------------------------------------------+---------------------------
//   req      | req_valid, req_stall, req_in_char,           | one string character
//            | req_is_final                                 |
//   rsp      | rsp_valid, rsp_stall, rsp_out_byte,          | one decoded byte
//            | rsp_run_last, rsp_string_done                |
//
// A request transaction lands in the input register, is decoded once the
// output queue has room for two bytes, and its zero, one or two result
// bytes enter that four-entry queue. One character per cycle is taken
// while req_stall is low; a character that yields two bytes leaves the
// queue one byte at a time through its single-byte read port.
// Reset (synchronous) returns the escape state to plain text and empties
// the input register and the queue.
// rsp_stall holds the queue; req_stall rises only while the input register
// is full and the queue lacks room for two more bytes.
module escape_sequence_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_done
);
   import esd_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_final_ff;

   logic       room;
   logic       dec_go;
   logic       req_take;
   push_type   push;
   result_type rsp_data;

   // decode advances whenever the queue can absorb the worst case of two bytes
   assign dec_go    = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (dec_go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff  <= req_in_char;
         in_final_ff <= req_is_final;
      end
   end

   esd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .go       (dec_go),
      .in_char  (in_char_ff),
      .is_final (in_final_ff),
      .push     (push)
   );

   esd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte    = rsp_data.out_byte;
   assign rsp_run_last    = rsp_data.run_last;
   assign rsp_string_done = rsp_data.string_done;

endmodule

@@ src/esd_decode.sv @@
// esd_decode: escape state registers and the per-character decode logic.
// Depends on esd_pkg.
module esd_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [7:0]        in_char,
   input  logic              is_final,
   output esd_pkg::push_type push
);
   import esd_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [3:0] nibble_ff, nibble_in;

   hex_type    hex;
   ctrl_type   ctrl;
   logic       is_digit;
   logic [1:0] n;
   logic [7:0] b0, b1;

   assign hex      = hex_value(in_char);
   assign ctrl     = control_byte(in_char);
   assign is_digit = (in_char >= 8'h30) && (in_char <= 8'h39);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PLAIN;
         nibble_ff <= 4'd0;
      end else if (go) begin
         mode_ff   <= mode_in;
         nibble_ff <= nibble_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      nibble_in = nibble_ff;
      n         = 2'd0;
      b0        = 8'h00;
      b1        = 8'h00;
      unique case (mode_ff)
         MODE_PLAIN: begin
            if (in_char == CHAR_BACKSLASH && !is_final) begin
               mode_in = MODE_ESC;
            end else begin
               n  = 2'd1;
               b0 = in_char;
            end
         end
         MODE_ESC: begin
            if (is_digit) begin
               nibble_in = in_char[3:0];
               mode_in   = (in_char == CHAR_ZERO) ? MODE_ZERO : MODE_HEX;
               if (is_final) begin
                  n  = 2'd1;
                  b0 = {4'd0, in_char[3:0]};
               end
            end else if (ctrl.ok) begin
               mode_in = MODE_PLAIN;
               n       = 2'd1;
               b0      = ctrl.value;
            end else begin
               // unknown escape: backslash, then the character as plain text
               mode_in = MODE_PLAIN;
               n       = 2'd2;
               b0      = CHAR_BACKSLASH;
               b1      = in_char;
            end
         end
         MODE_ZERO: begin
            if (hex.ok) begin
               nibble_in = hex.value;
               mode_in   = MODE_HEX;
               if (is_final) begin
                  n  = 2'd1;
                  b0 = {4'd0, hex.value};
               end
            end else begin
               mode_in = MODE_PLAIN;
               b0      = 8'h00;
               if (in_char == CHAR_BACKSLASH && !is_final) begin
                  mode_in = MODE_ESC;
                  n       = 2'd1;
               end else begin
                  n  = 2'd2;
                  b1 = in_char;
               end
            end
         end
         MODE_HEX: begin
            mode_in = MODE_PLAIN;
            if (hex.ok) begin
               n  = 2'd1;
               b0 = {nibble_ff, hex.value};
            end else begin
               b0 = {4'd0, nibble_ff};
               if (in_char == CHAR_BACKSLASH && !is_final) begin
                  mode_in = MODE_ESC;
                  n       = 2'd1;
               end else begin
                  n  = 2'd2;
                  b1 = in_char;
               end
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
         end
      endcase
      if (is_final) begin
         mode_in   = MODE_PLAIN;
         nibble_in = 4'd0;
      end
   end

   always_comb begin
      push.count               = go ? n : 2'd0;
      push.first.out_byte      = b0;
      push.first.run_last      = (n == 2'd1);
      push.first.string_done   = (n == 2'd1) && is_final;
      push.second.out_byte     = b1;
      push.second.run_last     = 1'b1;
      push.second.string_done  = is_final;
   end

endmodule

@@ src/esd_out_queue.sv @@
// esd_out_queue: small result queue taking up to two results per cycle, one out.
// Depends on esd_pkg.
module esd_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  esd_pkg::push_type   push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output esd_pkg::result_type rsp_data
);
   import esd_pkg::*;

   result_type                 entry_ff [OUT_DEPTH];
   logic [OUT_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUT_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUT_CNT_WIDTH-1:0]   count_ff, count_in;
   logic                       pop;
   logic [OUT_PTR_WIDTH-1:0]   wr_next;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign room      = (count_ff <= OUT_CNT_WIDTH'(OUT_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + OUT_PTR_WIDTH'(1);

   always_comb begin
      rd_ptr_in = rd_ptr_ff + OUT_PTR_WIDTH'(pop);
      wr_ptr_in = wr_ptr_ff + OUT_PTR_WIDTH'(push.count);
      count_in  = count_ff + OUT_CNT_WIDTH'(push.count) - OUT_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for escape_sequence_decoder: directed characters, then random strings.
// Depends on esd_pkg (mode enum, result struct, character constants) and the decoder RTL.
module tb;
   import esd_pkg::*;

   // handshake pressure
   localparam int IDLE_PCT     = 28;    // receiver stall odds per cycle
   localparam int GAP_PCT      = 20;    // sender gap odds per transaction
   localparam int HOLD_CYCLES  = 120;   // one long receiver hold-off
   localparam int HOLD_AT      = 300;
   localparam int PAUSE_AT     = 520;   // sender drains everything once mid-run
   localparam int CALM_FROM    = 650;   // stretch with no idling on either side
   localparam int CALM_TO      = 800;

   // run length and checking
   localparam int ITEM_TARGET  = 1050;
   localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either channel
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_MAX   = 10;

   localparam logic [63:0]  ESC_LETTERS = {"abtnvfr", CHAR_BACKSLASH};
   localparam logic [175:0] HEX_DIGITS  = "0123456789abcdefABCDEF";

   // one character to send; when typed is set, count/b0/b1 give the bytes it must produce
   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
      logic       typed;
      logic [1:0] count;
      logic [7:0] b0;
      logic [7:0] b1;
   } char_row_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char     = 8'h00;
   logic       req_is_final    = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_string_done;

   // typed expectation travels with the payload, so it is sampled at the same edge
   char_row_type pinned        = '0;

   logic       hold_go         = 1'b0;
   logic       hold_taken      = 1'b0;
   int         hold_left       = 0;
   logic       calm            = 1'b0;

   // decoder shadow state
   mode_type   esc_mode        = MODE_PLAIN;
   logic [3:0] esc_nibble      = 4'h0;
   logic [7:0] burst_q[$];          // bytes produced by the current character
   result_type awaited_bytes[$];    // expected responses, oldest first

   logic [8:0] line_q[$];           // {fin, char} of the next random string

   int         chars_sent      = 0;
   int         strings_done    = 0;
   int         bytes_checked   = 0;
   int         mismatches      = 0;
   int         quiet_cycles    = 0;
   int         ctl_hits        = 0;
   int         hex_hits        = 0;
   int         kept_hits       = 0;

   // Directed table: extremes, control escapes, unknown escape, hex escape
   // with both letter cases, hex cut short by a plain char and by a new
   // escape, and strings ending on an escape digit or a lone backslash.
   char_row_type directed [26] = '{
      '{8'h01,          1'b0, 1'b1, 2'd1, 8'h01,          8'h00},
      '{8'hFF,          1'b0, 1'b1, 2'd1, 8'hFF,          8'h00},
      '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,          8'h00},
      '{"a",            1'b0, 1'b1, 2'd1, 8'h07,          8'h00},
      '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,          8'h00},
      '{"r",            1'b0, 1'b1, 2'd1, 8'h0D,          8'h00},
      '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,          8'h00},
      '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd1, CHAR_BACKSLASH, 8'h00},
      '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,          8'h00},
      '{"q",            1'b0, 1'b1, 2'd2, CHAR_BACKSLASH, "q"  },
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 2'd0, 8'h00,          8'h00},
      '{"0",            1'b0, 1'b0, 2'd0, 8'h00,          8'h00},
      '{"f",            1'b0, 1'b0, 2'd0, 8'h00,          8'h00},
      '{"F",            1'b0, 1'b1, 2'd1, 8'hFF,          8'h00},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 2'd0, 8'h00,          8'h00},
      '{"7",            1'b0, 1'b0, 2'd0, 8'h00,          8'h00},
      '{"g",            1'b0, 1'b1, 2'd2, 8'h07,          "g"  },
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 2'd0, 8'h00,          8'h00},
      '{"0",            1'b0, 1'b0, 2'd0, 8'h00,          8'h00},
      '{CHAR_BACKSLASH, 1'b0, 1'b1, 2'd1, 8'h00,          8'h00},
      '{"t",            1'b0, 1'b1, 2'd1, 8'h09,          8'h00},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 2'd0, 8'h00,          8'h00},
      '{"0",            1'b1, 1'b1, 2'd1, 8'h00,          8'h00},
      '{CHAR_BACKSLASH, 1'b1, 1'b1, 2'd1, CHAR_BACKSLASH, 8'h00},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 2'd0, 8'h00,          8'h00},
      '{"5",            1'b1, 1'b1, 2'd1, 8'h05,          8'h00}
   };

   escape_sequence_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_char     (req_in_char),
      .req_is_final    (req_is_final),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow decoder
   // ---------------------------------------------------------------

   // hex digit value in [3:0]; bit 4 flags a non-hex character
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
      return 5'h10;
   endfunction

   // plain text: a backslash opens an escape unless it ends the string
   function automatic void plain_char(input logic [7:0] c, input logic fin);
      if (c == CHAR_BACKSLASH && !fin) esc_mode = MODE_ESC;
      else burst_q.push_back(c);
   endfunction

   // advance the shadow state by one character, appending its bytes to burst_q
   function automatic void decode_char(input logic [7:0] c, input logic fin);
      logic [4:0] h;
      logic [7:0] ctl;
      logic       is_ctl;
      h      = hex_digit(c);
      is_ctl = 1'b1;
      case (c)
         "a":            ctl = 8'h07;
         "b":            ctl = 8'h08;
         "t":            ctl = 8'h09;
         "n":            ctl = 8'h0A;
         "v":            ctl = 8'h0B;
         "f":            ctl = 8'h0C;
         "r":            ctl = 8'h0D;
         CHAR_BACKSLASH: ctl = CHAR_BACKSLASH;
         default: begin
            ctl    = 8'h00;
            is_ctl = 1'b0;
         end
      endcase
      case (esc_mode)
         MODE_PLAIN: plain_char(c, fin);
         MODE_ESC: begin
            if (c >= "0" && c <= "9") begin
               esc_nibble = c[3:0];
               esc_mode   = (c == CHAR_ZERO) ? MODE_ZERO : MODE_HEX;
               if (fin) begin
                  burst_q.push_back({4'h0, esc_nibble});
                  hex_hits++;
               end
            end else begin
               esc_mode = MODE_PLAIN;
               if (is_ctl) begin
                  burst_q.push_back(ctl);
                  ctl_hits++;
               end else begin
                  // unknown escape keeps the backslash, then the char as plain text
                  burst_q.push_back(CHAR_BACKSLASH);
                  kept_hits++;
                  plain_char(c, fin);
               end
            end
         end
         MODE_ZERO: begin
            if (!h[4]) begin
               esc_nibble = h[3:0];
               esc_mode   = MODE_HEX;
               if (fin) begin
                  burst_q.push_back({4'h0, esc_nibble});
                  hex_hits++;
               end
            end else begin
               esc_mode = MODE_PLAIN;
               burst_q.push_back(8'h00);
               hex_hits++;
               plain_char(c, fin);
            end
         end
         default: begin
            esc_mode = MODE_PLAIN;
            hex_hits++;
            if (!h[4]) burst_q.push_back({esc_nibble, h[3:0]});
            else begin
               burst_q.push_back({4'h0, esc_nibble});
               plain_char(c, fin);
            end
         end
      endcase
      if (fin) begin
         esc_mode   = MODE_PLAIN;
         esc_nibble = 4'h0;
      end
   endfunction

   // ---------------------------------------------------------------
   // Random strings: mostly well-formed escapes with random content,
   // some noise with end-of-string flags anywhere.
   // ---------------------------------------------------------------
   function automatic void compose_line();
      int         tokens;
      int         pick;
      int         t;
      int         k;
      logic [7:0] c;
      line_q.delete();
      if ($urandom_range(0, 99) < 10) begin
         tokens = $urandom_range(1, 10);
         for (t = 0; t < tokens; t++)
            line_q.push_back({1'($urandom_range(0, 99) < 15), 8'($urandom_range(1, 255))});
         return;
      end
      tokens = $urandom_range(1, 8);
      for (t = 0; t < tokens; t++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            c = 8'($urandom_range(1, 255));
            if (c == CHAR_BACKSLASH) c = "~";
            line_q.push_back({1'b0, c});
         end else begin
            line_q.push_back({1'b0, CHAR_BACKSLASH});
            if (pick < 55) begin
               k = $urandom_range(0, 7);
               line_q.push_back({1'b0, ESC_LETTERS[8*k +: 8]});
            end else if (pick < 80) begin
               // hex escape: \0h, \0hh, \d or \dh
               if ($urandom_range(0, 1)) begin
                  k = $urandom_range(0, 21);
                  line_q.push_back({1'b0, CHAR_ZERO});
                  line_q.push_back({1'b0, HEX_DIGITS[8*k +: 8]});
               end else begin
                  line_q.push_back({1'b0, 8'(CHAR_ZERO + $urandom_range(1, 9))});
               end
               if ($urandom_range(0, 1)) begin
                  k = $urandom_range(0, 21);
                  line_q.push_back({1'b0, HEX_DIGITS[8*k +: 8]});
               end
            end else if (pick < 90) begin
               line_q.push_back({1'b0, 8'($urandom_range(1, 255))});
            end else if (pick < 95) begin
               // digit left hanging: cut short by the next token or the string end
               line_q.push_back({1'b0, 8'(CHAR_ZERO + $urandom_range(0, 9))});
            end
            // otherwise a bare backslash, handled the same way
         end
      end
      c = line_q[line_q.size() - 1][7:0];
      line_q[line_q.size() - 1] = {1'b1, c};
   endfunction

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------

   // present one character and hold it until the transaction completes
   task automatic offer(input char_row_type row);
      req_valid    <= 1'b1;
      req_in_char  <= row.ch;
      req_is_final <= row.fin;
      pinned       <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
      if (!calm && $urandom_range(0, 99) < GAP_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // stop sending until every expected byte has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_bytes.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Receiver side: random stalls, one long hold-off, a calm stretch
   // ---------------------------------------------------------------
   always @(posedge clock) begin : receiver
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_taken) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (calm) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
   end

   // ---------------------------------------------------------------
   // Scoreboard: predict on each request transaction, check each
   // response transaction against the oldest expected byte.
   // Only expected traffic counts as progress for the watchdog.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      result_type seen;
      result_type want;
      int         k;
      logic       took;
      took = 1'b0;
      if (reset) begin
         esc_mode   = MODE_PLAIN;
         esc_nibble = 4'h0;
      end else begin
         if (req_valid && !req_stall) begin
            took = 1'b1;
            burst_q.delete();
            decode_char(req_in_char, req_is_final);
            if (pinned.typed) begin
               burst_q.delete();
               if (pinned.count > 0) burst_q.push_back(pinned.b0);
               if (pinned.count > 1) burst_q.push_back(pinned.b1);
            end
            for (k = 0; k < burst_q.size(); k++) begin
               want.out_byte    = burst_q[k];
               want.run_last    = (k == burst_q.size() - 1);
               want.string_done = want.run_last && req_is_final;
               awaited_bytes.push_back(want);
            end
            if (req_is_final) strings_done++;
         end
         if (rsp_valid && !rsp_stall) begin
            seen.out_byte    = rsp_out_byte;
            seen.run_last    = rsp_run_last;
            seen.string_done = rsp_string_done;
            if (awaited_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected response: out_byte %02h run_last %b string_done %b",
                           seen.out_byte, seen.run_last, seen.string_done);
            end else begin
               took = 1'b1;
               want = awaited_bytes.pop_front();
               bytes_checked++;
               if (seen.out_byte !== want.out_byte || seen.run_last !== want.run_last ||
                   seen.string_done !== want.string_done) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("response %0d: out_byte exp %02h got %02h, %s, %s",
                              bytes_checked, want.out_byte, seen.out_byte,
                              $sformatf("run_last exp %b got %b", want.run_last, seen.run_last),
                              $sformatf("string_done exp %b got %b",
                                        want.string_done, seen.string_done));
               end
            end
         end
         quiet_cycles = took ? 0 : quiet_cycles + 1;
      end
   end

   // no transaction on either channel for too long means the block hung
   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      char_row_type row;
      logic         paused;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) offer(directed[i]);
      wait_drained();

      while (chars_sent < ITEM_TARGET) begin
         compose_line();
         foreach (line_q[j]) begin
            row     = '0;
            row.ch  = line_q[j][7:0];
            row.fin = line_q[j][8];
            offer(row);
            hold_go <= (chars_sent >= HOLD_AT);
            calm    <= (chars_sent >= CALM_FROM && chars_sent < CALM_TO);
         end
         if (!paused && chars_sent >= PAUSE_AT) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatches += awaited_bytes.size();

      $display("covered %0d characters in %0d strings, %0d decoded bytes compared",
               chars_sent, strings_done, bytes_checked);
      $display("escapes: %0d control, %0d hex, %0d backslashes kept; %0d mismatches",
               ctl_hits, hex_hits, kept_hits, mismatches);
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
